[design/event_channel_dispatch_macros.svh]
// Assertion helpers
`ifndef EVENT_CHANNEL_DISPATCH_MACROS_SVH
`define EVENT_CHANNEL_DISPATCH_MACROS_SVH

`define ECD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ECD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/ecd_pkg.sv]
package ecd_pkg;

	typedef enum logic [2:0] {
		OP_RAISE  = 3'd0,
		OP_MASK   = 3'd1,
		OP_UNMASK = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_NEXT   = 3'd4
	} op_t;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_DELIVERED = 2'd1;
	localparam logic [1:0] ST_NONE      = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [9:0] port;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] port_out;
		logic       upcall_flag;
		logic       callback_request;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SCAN = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_next;
		logic scan_done;
	} sts_t;

endpackage

[design/ecd_ctrl.sv]
module ecd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ecd_pkg::sts_t sts,
	output ecd_pkg::cmd_t cmd
);

	`include "event_channel_dispatch_macros.svh"

	ecd_pkg::state_t state_q, state_d;

	assign in_stall  = (state_q != ecd_pkg::S_IDLE);
	assign out_valid = (state_q == ecd_pkg::S_OUT);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		case (state_q)
			ecd_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ecd_pkg::S_READ;
				end
			end
			ecd_pkg::S_READ: begin
				if (sts.is_next) begin
					state_d = ecd_pkg::S_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d  = ecd_pkg::S_OUT;
				end
			end
			ecd_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ecd_pkg::S_OUT;
			end
			ecd_pkg::S_OUT: begin
				if (!out_stall) state_d = ecd_pkg::S_IDLE;
			end
			default: state_d = ecd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ecd_pkg::S_IDLE;
		else state_q <= state_d;
	end

	`ECD_ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_q))
	`ECD_ASSERT_IMPL(a_excl, out_valid, in_stall)
	`ECD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)

endmodule

[design/ecd_dp.sv]
module ecd_dp #(
	parameter int NUM_WORDS  = 32,
	parameter int WORD_SHIFT = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ecd_pkg::req_t req,
	input  logic          upcall_masked,
	input  ecd_pkg::cmd_t cmd,
	output ecd_pkg::sts_t sts,
	output ecd_pkg::rsp_t rsp
);

	localparam int WB = 1 << WORD_SHIFT;
	localparam int WI = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	logic [NUM_WORDS-1:0][WB-1:0] pend_q, mask_q;
	logic [NUM_WORDS-1:0] sel_q, snap_q;
	logic                 upc_q;
	ecd_pkg::req_t        req_q;
	ecd_pkg::rsp_t        rsp_q;
	logic [WB-1:0]        pw_q, mw_q;
	logic                 wok_q;
	logic                 scan_q;

	logic [9-WORD_SHIFT:0] wfull;
	logic [WI-1:0]         w;
	logic                  wok;

	assign wfull = req.port[9:WORD_SHIFT];
	assign w     = wfull[WI-1:0];
	assign wok   = (32'(wfull) < 32'(NUM_WORDS));

	logic [9-WORD_SHIFT:0] wf_q;
	logic [WI-1:0]         w_q;
	logic [WORD_SHIFT-1:0] b_q;
	assign wf_q = req_q.port[9:WORD_SHIFT];
	assign w_q  = wf_q[WI-1:0];
	assign b_q  = req_q.port[WORD_SHIFT-1:0];

	// scan: current snapshot (loaded from selector if empty)
	logic [NUM_WORDS-1:0] snap_cur;
	logic [WI-1:0]        sw;
	logic                 sw_any;
	logic [WB-1:0]        act;
	logic [WORD_SHIFT-1:0] sb;
	logic                 act_any;

	always_comb begin
		snap_cur = cmd.scan && (snap_q == '0) && !scan_q ? sel_q : snap_q;
		sw = '0; sw_any = 1'b0;
		for (int i = NUM_WORDS - 1; i >= 0; i--) begin
			if (snap_cur[i]) begin sw = WI'(i); sw_any = 1'b1; end
		end
		act = pend_q[sw] & ~mask_q[sw];
		sb = '0; act_any = 1'b0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (act[i]) begin sb = WORD_SHIFT'(i); act_any = 1'b1; end
		end
	end

	assign sts.is_next   = (req_q.op == ecd_pkg::OP_NEXT);
	assign sts.scan_done = !sw_any || act_any;
	assign rsp           = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			mask_q <= '1;
			sel_q  <= '0;
			snap_q <= '0;
			upc_q  <= 1'b0;
			wok_q  <= 1'b0;
			scan_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				wok_q  <= wok;
				scan_q <= 1'b0;
			end
			if (cmd.exec && wok_q) begin
				case (req_q.op)
					ecd_pkg::OP_RAISE: begin
						pend_q[w_q][b_q] <= 1'b1;
						if (!pw_q[b_q] && !mw_q[b_q]) begin
							sel_q[w_q] <= 1'b1;
							upc_q      <= 1'b1;
						end
					end
					ecd_pkg::OP_MASK: mask_q[w_q][b_q] <= 1'b1;
					ecd_pkg::OP_UNMASK: begin
						mask_q[w_q][b_q] <= 1'b0;
						if (pw_q[b_q] && !sel_q[w_q]) begin
							sel_q[w_q] <= 1'b1;
							upc_q      <= 1'b1;
						end
					end
					ecd_pkg::OP_CLEAR: pend_q[w_q][b_q] <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.scan) begin
				scan_q <= 1'b1;
				if (!scan_q && snap_q == '0) begin
					sel_q <= '0;
					upc_q <= 1'b0;
				end
				if (sw_any && act_any) begin
					pend_q[sw][sb] <= 1'b0;
					snap_q <= snap_cur;
				end else if (sw_any) begin
					snap_q <= snap_cur & ~(NUM_WORDS'(1) << sw);
				end else begin
					snap_q <= snap_cur;
				end
			end
		end
	end

	logic [9:0] port_calc;
	assign port_calc = 10'(({{(10 - WI){1'b0}}, sw} << WORD_SHIFT) | 10'(sb));

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
			pw_q  <= pend_q[w];
			mw_q  <= mask_q[w];
		end
		if (cmd.exec) begin
			rsp_q.status   <= ecd_pkg::ST_DONE;
			rsp_q.port_out <= '0;
			rsp_q.upcall_flag <= (wok_q && req_q.op == ecd_pkg::OP_RAISE
				&& !pw_q[b_q] && !mw_q[b_q]) ||
				(wok_q && req_q.op == ecd_pkg::OP_UNMASK && pw_q[b_q] && !sel_q[w_q])
				|| upc_q;
			rsp_q.callback_request <= wok_q && req_q.op == ecd_pkg::OP_UNMASK
				&& pw_q[b_q] && !sel_q[w_q] && !upcall_masked;
		end
		if (cmd.scan && sts.scan_done) begin
			rsp_q.status   <= act_any && sw_any ? ecd_pkg::ST_DELIVERED : ecd_pkg::ST_NONE;
			rsp_q.port_out <= act_any && sw_any ? port_calc : 10'd0;
			rsp_q.upcall_flag <= (!scan_q && snap_q == '0) ? 1'b0 : upc_q;
			rsp_q.callback_request <= 1'b0;
		end
	end

endmodule

[design/event_channel_dispatch.sv]
// Two-level pending-bitmap event controller. One request (op, port) gives one
// response. For raise, mask, unmask and clear the addressed pending and mask
// words are read into a register after acceptance, then modified and written
// back as the response is registered. A next request scans one snapshot word per
// cycle, skipping words with no active port, until it finds an active port or the
// snapshot is empty. One request is in flight at a time; input stall is high until
// the response is taken, so no new request is accepted before then.
module event_channel_dispatch #(
	parameter int NUM_WORDS  = 32,
	parameter int WORD_SHIFT = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ecd_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output ecd_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	logic          upcall_masked_q;
	ecd_pkg::cmd_t cmd;
	ecd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) upcall_masked_q <= 1'b1;
		else if (cfg_valid) upcall_masked_q <= cfg_data;
	end

	ecd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	ecd_dp #(.NUM_WORDS(NUM_WORDS), .WORD_SHIFT(WORD_SHIFT)) u_dp (
		.clk, .arst_n, .req(in_data), .upcall_masked(upcall_masked_q),
		.cmd, .sts, .rsp(out_data)
	);

endmodule
